[sv/rgbhsl_pkg.sv]
// Package for the RGB to HSL converter: payload structs, internal work item
// and fixed arithmetic constants. No dependencies.
`default_nettype none

package rgbhsl_pkg;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned HUE_W     = 15;
  localparam int unsigned LIGHT_W   = 9;
  localparam int unsigned HUE_NUM_W = 20;
  localparam int unsigned SAT_NUM_W = 16;
  localparam int unsigned QUO_W     = 12;

  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_GREEN  = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE   = 15'd15360;
  localparam logic [LIGHT_W-1:0] MID_LIGHT = 9'd255;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]   hue_out;
    logic [CHAN_W-1:0]  saturation_out;
    logic [LIGHT_W-1:0] lightness_out;
  } hsl_t;

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

  typedef struct packed {
    logic [HUE_NUM_W-1:0] hue_num;
    logic [SAT_NUM_W-1:0] sat_num;
    logic [CHAN_W-1:0]    chroma;
    logic [CHAN_W-1:0]    den;
    logic                 neg;
    sector_t              sector;
    logic                 grey;
    logic [LIGHT_W-1:0]   lightness;
  } work_t;

  typedef struct packed {
    logic               neg;
    sector_t            sector;
    logic [LIGHT_W-1:0] lightness;
  } hue_side_t;

endpackage

`default_nettype wire

[sv/rgbhsl_front.sv]
// Front end of the RGB to HSL converter: takes pixel transfers, finds max,
// min and chroma, picks the hue sector and forms the dividends. Uses rgbhsl_pkg.
`default_nettype none

module rgbhsl_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire rgbhsl_pkg::pixel_t pixel,
  output logic                   busy,
  input  wire logic              queue_full,
  output logic                   push,
  output rgbhsl_pkg::work_t      work
);

  logic                           vld;
  logic [rgbhsl_pkg::CHAN_W-1:0]  mx;
  logic [rgbhsl_pkg::CHAN_W-1:0]  mn;
  logic [rgbhsl_pkg::CHAN_W-1:0]  chroma;
  logic [rgbhsl_pkg::LIGHT_W-1:0] light;
  logic [rgbhsl_pkg::LIGHT_W-1:0] light_dev;
  logic [rgbhsl_pkg::CHAN_W:0]    diff;
  logic [rgbhsl_pkg::CHAN_W:0]    diff_abs;
  logic [rgbhsl_pkg::CHAN_W-1:0]  mag;
  rgbhsl_pkg::sector_t            sector;
  rgbhsl_pkg::work_t              work_next;
  logic                           accept;

  assign busy   = vld && queue_full;
  assign push   = vld && !queue_full;
  assign accept = start && !busy;

  always_comb begin
    mx = pixel.red_in;
    mn = pixel.red_in;
    if (pixel.green_in > mx) mx = pixel.green_in;
    if (pixel.blue_in > mx) mx = pixel.blue_in;
    if (pixel.green_in < mn) mn = pixel.green_in;
    if (pixel.blue_in < mn) mn = pixel.blue_in;
    chroma = mx - mn;
    light  = {1'b0, mx} + {1'b0, mn};
    light_dev = (light >= rgbhsl_pkg::MID_LIGHT) ? (light - rgbhsl_pkg::MID_LIGHT)
                                                 : (rgbhsl_pkg::MID_LIGHT - light);
    if (mx == pixel.red_in) begin
      sector = rgbhsl_pkg::SECTOR_RED;
      diff   = {1'b0, pixel.green_in} - {1'b0, pixel.blue_in};
    end else if (mx == pixel.green_in) begin
      sector = rgbhsl_pkg::SECTOR_GREEN;
      diff   = {1'b0, pixel.blue_in} - {1'b0, pixel.red_in};
    end else begin
      sector = rgbhsl_pkg::SECTOR_BLUE;
      diff   = {1'b0, pixel.red_in} - {1'b0, pixel.green_in};
    end
    diff_abs = diff[rgbhsl_pkg::CHAN_W] ? (~diff + 1'b1) : diff;
    mag      = diff_abs[rgbhsl_pkg::CHAN_W-1:0];

    work_next.hue_num   = rgbhsl_pkg::HUE_NUM_W'(mag) *
                          rgbhsl_pkg::HUE_NUM_W'(rgbhsl_pkg::HUE_SECTOR);
    work_next.sat_num   = rgbhsl_pkg::SAT_NUM_W'(chroma) * 16'd255;
    work_next.chroma    = chroma;
    work_next.den       = rgbhsl_pkg::CHAN_W'(rgbhsl_pkg::MID_LIGHT - light_dev);
    work_next.neg       = diff[rgbhsl_pkg::CHAN_W];
    work_next.sector    = sector;
    work_next.grey      = (chroma == '0);
    work_next.lightness = light;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!busy) begin
      vld <= accept;
    end
    if (accept) begin
      work <= work_next;
    end
  end

endmodule

`default_nettype wire

[sv/rgbhsl_queue.sv]
// Short queue between the converter's front and back ends. Register array
// with a fill count; read data is taken straight from the head entry.
`default_nettype none

module rgbhsl_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rgbhsl_pkg::work_t wr_data,
  input  wire logic              pop,
  output logic                   full,
  output logic                   empty,
  output rgbhsl_pkg::work_t      rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rgbhsl_pkg::work_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[sv/rgbhsl_div.sv]
// Pipelined restoring divider for the converter, one quotient bit per stage,
// with a sideband carried alongside. The quotient must fit in QUO_W bits.
`default_nettype none

module rgbhsl_div #(
  parameter int unsigned NUM_W  = 20,
  parameter int unsigned DEN_W  = 8,
  parameter int unsigned QUO_W  = 12,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_vld,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_vld,
  output logic [QUO_W-1:0]       out_quo,
  output logic                   out_rem_nz,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int unsigned CMP_W = (NUM_W > DEN_W + QUO_W - 1) ? NUM_W
                                                              : DEN_W + QUO_W - 1;

  logic              vld_s  [QUO_W+1];
  logic [NUM_W-1:0]  rem_s  [QUO_W+1];
  logic [DEN_W-1:0]  den_s  [QUO_W+1];
  logic [QUO_W-1:0]  quo_s  [QUO_W+1];
  logic [SIDE_W-1:0] side_s [QUO_W+1];

  assign vld_s[0]  = in_vld;
  assign rem_s[0]  = in_num;
  assign den_s[0]  = in_den;
  assign quo_s[0]  = '0;
  assign side_s[0] = in_side;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] trial;
    logic             fits;

    assign rem_ext = CMP_W'(rem_s[k]);
    assign trial   = CMP_W'(den_s[k]) << (QUO_W - 1 - k);
    assign fits    = (rem_ext >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vld_s[k];
      end
      rem_s[k+1]  <= fits ? NUM_W'(rem_ext - trial) : rem_s[k];
      den_s[k+1]  <= den_s[k];
      quo_s[k+1]  <= {quo_s[k][QUO_W-2:0], fits};
      side_s[k+1] <= side_s[k];
    end
  end

  assign out_vld    = vld_s[QUO_W];
  assign out_quo    = quo_s[QUO_W];
  assign out_rem_nz = (rem_s[QUO_W] != '0);
  assign out_side   = side_s[QUO_W];

endmodule

`default_nettype wire

[sv/rgbhsl_back.sv]
// Back end of the RGB to HSL converter: pops the queue when not empty, runs
// the hue and saturation dividers and registers the result. Uses rgbhsl_pkg.
`default_nettype none

module rgbhsl_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              queue_empty,
  input  wire rgbhsl_pkg::work_t work,
  output logic                   pop,
  output logic                   done,
  output rgbhsl_pkg::hsl_t       result
);

  rgbhsl_pkg::hue_side_t            side_in;
  rgbhsl_pkg::hue_side_t            side_out;
  logic [$bits(rgbhsl_pkg::hue_side_t)-1:0] side_bits;
  logic                             hue_vld;
  logic                             sat_vld;
  logic [rgbhsl_pkg::QUO_W-1:0]     hue_quo;
  logic [rgbhsl_pkg::QUO_W-1:0]     sat_quo;
  logic                             hue_rem_nz;
  logic                             sat_rem_nz;
  logic                             grey_out;
  logic [rgbhsl_pkg::HUE_W-1:0]     base;
  logic [rgbhsl_pkg::HUE_W-1:0]     hue_raw;
  rgbhsl_pkg::hsl_t                 result_next;

  assign pop = !queue_empty;

  assign side_in.neg       = work.neg;
  assign side_in.sector    = work.sector;
  assign side_in.lightness = work.lightness;

  rgbhsl_div #(
    .NUM_W (rgbhsl_pkg::HUE_NUM_W),
    .DEN_W (rgbhsl_pkg::CHAN_W),
    .QUO_W (rgbhsl_pkg::QUO_W),
    .SIDE_W($bits(rgbhsl_pkg::hue_side_t))
  ) u_hue_div (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (pop),
    .in_num    (work.hue_num),
    .in_den    (work.chroma),
    .in_side   (side_in),
    .out_vld   (hue_vld),
    .out_quo   (hue_quo),
    .out_rem_nz(hue_rem_nz),
    .out_side  (side_bits)
  );

  rgbhsl_div #(
    .NUM_W (rgbhsl_pkg::SAT_NUM_W),
    .DEN_W (rgbhsl_pkg::CHAN_W),
    .QUO_W (rgbhsl_pkg::QUO_W),
    .SIDE_W(1)
  ) u_sat_div (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (pop),
    .in_num    (work.sat_num),
    .in_den    (work.den),
    .in_side   (work.grey),
    .out_vld   (sat_vld),
    .out_quo   (sat_quo),
    .out_rem_nz(sat_rem_nz),
    .out_side  (grey_out)
  );

  assign side_out = rgbhsl_pkg::hue_side_t'(side_bits);

  always_comb begin
    case (side_out.sector)
      rgbhsl_pkg::SECTOR_RED:   base = side_out.neg ? rgbhsl_pkg::HUE_FULL : '0;
      rgbhsl_pkg::SECTOR_GREEN: base = rgbhsl_pkg::HUE_GREEN;
      rgbhsl_pkg::SECTOR_BLUE:  base = rgbhsl_pkg::HUE_BLUE;
      default:                  base = '0;
    endcase
    // A negative numerator needs the ceiling of the quotient taken off.
    if (side_out.neg) begin
      hue_raw = base - rgbhsl_pkg::HUE_W'(hue_quo) - rgbhsl_pkg::HUE_W'(hue_rem_nz);
    end else begin
      hue_raw = base + rgbhsl_pkg::HUE_W'(hue_quo);
    end
    if (hue_raw >= rgbhsl_pkg::HUE_FULL) begin
      hue_raw = hue_raw - rgbhsl_pkg::HUE_FULL;
    end
    result_next.lightness_out  = side_out.lightness;
    result_next.hue_out        = grey_out ? '0 : hue_raw;
    // The remainder of the saturation divide plays no part in a floored result.
    result_next.saturation_out = (grey_out || (sat_rem_nz && 1'b0)) ? '0
                                 : sat_quo[rgbhsl_pkg::CHAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= hue_vld && sat_vld;
    end
    result <= result_next;
  end

endmodule

`default_nettype wire

[sv/rgb_to_hsl_converter.sv]
// Top level of the RGB to HSL converter: front end, queue and back end.
// Depends on rgbhsl_pkg, rgbhsl_front, rgbhsl_queue and rgbhsl_back.
//
// A pixel transfer takes place at a rising edge where start is high and busy
// is low; one pixel may be transferred on every clock cycle. Each pixel gives
// one result, shown on result with done high for exactly one cycle, and
// results leave in the order pixels arrived. The receiver cannot stall the
// block, so the back end drains the queue on every cycle and busy stays low
// in operation. The latency is set by the two pipelined dividers for hue and
// saturation, which resolve one quotient bit per stage over twelve stages,
// plus the front register, the queue and the output register. Hue is in
// sixty-fourths of a degree, lightness is max plus min and a grey pixel
// gives zero hue and saturation.
`default_nettype none

module rgb_to_hsl_converter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire rgbhsl_pkg::pixel_t pixel,
  output logic                    busy,
  output logic                    done,
  output rgbhsl_pkg::hsl_t        result
);

  rgbhsl_pkg::work_t front_work;
  rgbhsl_pkg::work_t queue_work;
  logic              push;
  logic              pop;
  logic              queue_full;
  logic              queue_empty;

  rgbhsl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .pixel     (pixel),
    .busy      (busy),
    .queue_full(queue_full),
    .push      (push),
    .work      (front_work)
  );

  rgbhsl_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(front_work),
    .pop    (pop),
    .full   (queue_full),
    .empty  (queue_empty),
    .rd_data(queue_work)
  );

  rgbhsl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .queue_empty(queue_empty),
    .work       (queue_work),
    .pop        (pop),
    .done       (done),
    .result     (result)
  );

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for rgb_to_hsl_converter: directed corner pixels, then a random
// stream with random gaps, each result checked against a local integer model of the conversion.
// Depends on rgbhsl_pkg and rgb_to_hsl_converter.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned MAX_GAP = 11;
  localparam int unsigned REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  rgbhsl_pkg::pixel_t pixel = '0;
  logic busy;
  logic done;
  rgbhsl_pkg::hsl_t result;

  rgbhsl_pkg::hsl_t hsl_expected[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  rgb_to_hsl_converter dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .pixel(pixel),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic rgbhsl_pkg::hsl_t convert_pixel(input rgbhsl_pkg::pixel_t p);
    int r, g, b, hi, lo, chroma, light, num, base, wrapped, hue, light_dev, den, sat;
    int span, full;
    rgbhsl_pkg::sector_t sector;
    rgbhsl_pkg::hsl_t res;
    r = int'(p.red_in);
    g = int'(p.green_in);
    b = int'(p.blue_in);
    span = int'(rgbhsl_pkg::HUE_SECTOR);
    full = int'(rgbhsl_pkg::HUE_FULL);
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    chroma = hi - lo;
    light = hi + lo;
    hue = 0;
    sat = 0;
    if (chroma != 0) begin
      if (hi == r) sector = rgbhsl_pkg::SECTOR_RED;
      else if (hi == g) sector = rgbhsl_pkg::SECTOR_GREEN;
      else sector = rgbhsl_pkg::SECTOR_BLUE;
      case (sector)
        rgbhsl_pkg::SECTOR_RED: begin
          num = g - b;
          base = 0;
        end
        rgbhsl_pkg::SECTOR_GREEN: begin
          num = b - r;
          base = int'(rgbhsl_pkg::HUE_GREEN);
        end
        default: begin
          num = r - g;
          base = int'(rgbhsl_pkg::HUE_BLUE);
        end
      endcase
      if (num >= 0) begin
        hue = (span * num) / chroma + base;
      end else begin
        // Floor is taken on the wrapped, nonnegative numerator.
        wrapped = (base == 0) ? full : base;
        hue = (wrapped * chroma - span * (-num)) / chroma;
      end
      if (hue >= full) hue = hue - full;
      light_dev = (light >= 255) ? light - 255 : 255 - light;
      den = 255 - light_dev;
      if (den != 0) sat = (chroma * 255) / den;
      if (sat > 255) sat = 255;
    end
    res.hue_out = hue[rgbhsl_pkg::HUE_W-1:0];
    res.saturation_out = sat[rgbhsl_pkg::CHAN_W-1:0];
    res.lightness_out = light[rgbhsl_pkg::LIGHT_W-1:0];
    return res;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    rgbhsl_pkg::hsl_t want;
    if (!rst && done) begin
      if (hsl_expected.size() == 0) begin
        flag_error($sformatf("result %0d/%0d/%0d with no pixel outstanding",
                             result.hue_out, result.saturation_out, result.lightness_out));
      end else begin
        want = hsl_expected.pop_front();
        if (result.hue_out !== want.hue_out)
          flag_error($sformatf("hue expected %0d actual %0d", want.hue_out, result.hue_out));
        if (result.saturation_out !== want.saturation_out)
          flag_error($sformatf("saturation expected %0d actual %0d",
                               want.saturation_out, result.saturation_out));
        if (result.lightness_out !== want.lightness_out)
          flag_error($sformatf("lightness expected %0d actual %0d",
                               want.lightness_out, result.lightness_out));
      end
    end
  end

  // Called at a rising edge; returns at the edge on which the transfer took place.
  task automatic send_pixel(input rgbhsl_pkg::pixel_t p, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel <= p;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    hsl_expected.push_back(convert_pixel(p));
  endtask

  task automatic send_rgb(input int r, input int g, input int b);
    rgbhsl_pkg::pixel_t p;
    p.red_in = r[7:0];
    p.green_in = g[7:0];
    p.blue_in = b[7:0];
    send_pixel(p, $urandom_range(0, MAX_GAP));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (hsl_expected.size() != 0);
  endtask

  function automatic logic [7:0] jitter(input int v);
    int x;
    x = v + int'($urandom_range(0, 4)) - 2;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return x[7:0];
  endfunction

  function automatic rgbhsl_pkg::pixel_t random_pixel();
    rgbhsl_pkg::pixel_t p;
    int v;
    p = rgbhsl_pkg::pixel_t'($urandom);
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        v = int'($urandom_range(0, 255));
        p.red_in = jitter(v);
        p.green_in = jitter(v);
        p.blue_in = jitter(v);
      end
      2: begin
        case ($urandom_range(0, 2))
          0: p.green_in = p.red_in;
          1: p.blue_in = p.red_in;
          default: p.blue_in = p.green_in;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1)) p.red_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
        if ($urandom_range(0, 1)) p.green_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
        if ($urandom_range(0, 1)) p.blue_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
    endcase
    return p;
  endfunction

  task automatic test_grey_and_extremes();
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    send_rgb(128, 128, 128);
    send_rgb(255, 0, 0);
    send_rgb(0, 255, 0);
    send_rgb(0, 0, 255);
    send_rgb(1, 0, 0);
    send_rgb(255, 254, 254);
    send_rgb(128, 127, 127);
    send_rgb(170, 85, 85);
  endtask

  task automatic test_sector_ties_and_wrap();
    send_rgb(255, 255, 0);
    send_rgb(0, 255, 255);
    send_rgb(255, 0, 255);
    send_rgb(200, 200, 200);
    send_rgb(255, 0, 1);
    send_rgb(1, 255, 0);
    send_rgb(0, 1, 255);
    send_rgb(200, 3, 10);
    send_rgb(7, 90, 3);
    send_rgb(100, 99, 101);
    send_rgb(85, 170, 255);
  endtask

  task automatic test_drain_pause();
    repeat (6) send_pixel(random_pixel(), 0);
    wait_idle();
    repeat (6) send_pixel(random_pixel(), $urandom_range(0, MAX_GAP));
    wait_idle();
  endtask

  task automatic test_random_stream(input int unsigned n_items);
    int unsigned sent;
    bit burst;
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(0, 2) == 0);
      repeat (20) begin
        send_pixel(random_pixel(), burst ? 0 : $urandom_range(0, MAX_GAP));
        sent++;
      end
      if ($urandom_range(0, 7) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_grey_and_extremes();
    test_sector_ties_and_wrap();
    test_drain_pause();
    test_random_stream(380);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
